// ===== design/tli_pkg.sv =====
// Shared widths, types and constants of the trilinear interpolator.
package tli_pkg;

	localparam int OFS_W     = 16;  // offsets
	localparam int CS_W      = 16;  // cell sizes
	localparam int VAL_W     = 32;  // corner values and result, Q16.16
	localparam int AX_W      = OFS_W + 1;       // signed offset and complement
	localparam int XY_W      = 2 * AX_W;        // x*y product
	localparam int WGT_W     = 49;              // |weight| < 2^48
	localparam int VOL_W     = 3 * CS_W;        // cell volume
	localparam int PL_W      = VAL_W + 33;      // corner * low weight word
	localparam int PH_W      = VAL_W + WGT_W - 32; // corner * high weight word
	localparam int TERM_W    = PH_W + 32;       // one weighted corner
	localparam int ACC_W     = TERM_W + 3;      // sum of eight terms
	localparam int QUO_W     = 32;              // quotient bits kept
	localparam int N_CORNER  = 8;
	localparam int REG_IDX_W = 2;

	localparam logic [CS_W-1:0] CS_RESET = 16'd256;

	localparam logic [REG_IDX_W-1:0] REG_CELL_SIZE_X = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CELL_SIZE_Y = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CELL_SIZE_Z = 2'd2;

	localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

	// Per corner: which x*y product (0: x1y1, 1: x0y1, 2: x1y0, 3: x0y0)
	// and whether z0 (bit set) or z1 completes the weight.
	localparam logic [1:0] WGT_XY [N_CORNER] = '{2'd0, 2'd1, 2'd2, 2'd0,
		2'd3, 2'd1, 2'd2, 2'd3};
	localparam logic [N_CORNER-1:0] WGT_Z0 = 8'b1110_1000;

	typedef logic [N_CORNER-1:0][VAL_W-1:0] corners_t;
	typedef logic [N_CORNER-1:0][WGT_W-1:0] weights_t;

	typedef struct packed {
		logic              valid;
		corners_t          corner;
		weights_t          weight;
		logic [VOL_W-1:0]  vol;
	} wgt_bus_t;

	typedef struct packed {
		logic              valid;
		logic [ACC_W-1:0]  sum;
		logic [VOL_W-1:0]  vol;
	} sum_bus_t;

	typedef struct packed {
		logic              valid;
		logic [VAL_W-1:0]  value;
		logic              sat;
	} res_bus_t;

endpackage

// ===== design/tli_if.sv =====
// Sample and result channel interfaces of the trilinear interpolator.
interface tli_sample_if import tli_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OFS_W-1:0]        offset_x;
	logic [OFS_W-1:0]        offset_y;
	logic [OFS_W-1:0]        offset_z;
	logic signed [VAL_W-1:0] corner_000;
	logic signed [VAL_W-1:0] corner_100;
	logic signed [VAL_W-1:0] corner_010;
	logic signed [VAL_W-1:0] corner_001;
	logic signed [VAL_W-1:0] corner_110;
	logic signed [VAL_W-1:0] corner_101;
	logic signed [VAL_W-1:0] corner_011;
	logic signed [VAL_W-1:0] corner_111;

	modport source (output valid, offset_x, offset_y, offset_z, corner_000, corner_100,
		corner_010, corner_001, corner_110, corner_101, corner_011, corner_111,
		input ready);
	modport sink (input valid, offset_x, offset_y, offset_z, corner_000, corner_100,
		corner_010, corner_001, corner_110, corner_101, corner_011, corner_111,
		output ready);
endinterface

interface tli_result_if import tli_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] interpolated_value;
	logic                    saturated;

	modport source (output valid, interpolated_value, saturated, input ready);
	modport sink (input valid, interpolated_value, saturated, output ready);
endinterface

// ===== design/tli_weights.sv =====
// Weight stages: offset complements, x*y products, corner weights and cell volume.
module tli_weights import tli_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  logic [OFS_W-1:0] offset_x,
	input  logic [OFS_W-1:0] offset_y,
	input  logic [OFS_W-1:0] offset_z,
	input  corners_t         corner,
	input  logic [CS_W-1:0]  cell_size_x,
	input  logic [CS_W-1:0]  cell_size_y,
	input  logic [CS_W-1:0]  cell_size_z,
	output wgt_bus_t         wgt
);

	// stage 1
	logic                   v_s1;
	logic signed [AX_W-1:0] x0_s1, y0_s1, z0_s1, x1_s1, y1_s1, z1_s1;
	corners_t               corner_s1;
	logic [2*CS_W-1:0]      csxy_s1;
	logic [CS_W-1:0]        csz_s1;
	// stage 2
	logic                   v_s2;
	logic signed [XY_W-1:0] xy_s2 [4];
	logic signed [AX_W-1:0] z0_s2, z1_s2;
	corners_t               corner_s2;
	logic [VOL_W-1:0]       vol_s2;
	// stage 3
	logic                   v_s3;
	weights_t               w_s3;
	corners_t               corner_s3;
	logic [VOL_W-1:0]       vol_s3;

	logic signed [XY_W+AX_W-1:0] w_full [N_CORNER];

	always_comb begin
		for (int i = 0; i < N_CORNER; i++) begin
			w_full[i] = xy_s2[WGT_XY[i]] * (WGT_Z0[i] ? z0_s2 : z1_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_s1     <= $signed({1'b0, offset_x});
			y0_s1     <= $signed({1'b0, offset_y});
			z0_s1     <= $signed({1'b0, offset_z});
			x1_s1     <= $signed({1'b0, cell_size_x}) - $signed({1'b0, offset_x});
			y1_s1     <= $signed({1'b0, cell_size_y}) - $signed({1'b0, offset_y});
			z1_s1     <= $signed({1'b0, cell_size_z}) - $signed({1'b0, offset_z});
			corner_s1 <= corner;
			csxy_s1   <= cell_size_x * cell_size_y;
			csz_s1    <= cell_size_z;

			xy_s2[0]  <= x1_s1 * y1_s1;
			xy_s2[1]  <= x0_s1 * y1_s1;
			xy_s2[2]  <= x1_s1 * y0_s1;
			xy_s2[3]  <= x0_s1 * y0_s1;
			z0_s2     <= z0_s1;
			z1_s2     <= z1_s1;
			corner_s2 <= corner_s1;
			vol_s2    <= csxy_s1 * csz_s1;

			for (int i = 0; i < N_CORNER; i++) begin
				w_s3[i] <= w_full[i][WGT_W-1:0];
			end
			corner_s3 <= corner_s2;
			vol_s3    <= vol_s2;
		end
	end

	assign wgt.valid  = v_s3;
	assign wgt.corner = corner_s3;
	assign wgt.weight = w_s3;
	assign wgt.vol    = vol_s3;

endmodule

// ===== design/tli_mac.sv =====
// Multiply stages: corner times weight in split partial products, then an adder tree.
module tli_mac import tli_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  wgt_bus_t wgt,
	output sum_bus_t acc
);

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [PL_W-1:0]   pl_s1 [N_CORNER];
	logic signed [PH_W-1:0]   ph_s1 [N_CORNER];
	logic [TERM_W-1:0]        term_s2 [N_CORNER];
	logic [ACC_W-1:0]         sum_s3 [4];
	logic [ACC_W-1:0]         sum_s4 [2];
	logic [ACC_W-1:0]         sum_s5;
	logic [VOL_W-1:0]         vol_s1, vol_s2, vol_s3, vol_s4, vol_s5;

	logic [ACC_W-1:0]         term_x [N_CORNER];

	always_comb begin
		for (int i = 0; i < N_CORNER; i++) begin
			term_x[i] = {{(ACC_W-TERM_W){term_s2[i][TERM_W-1]}}, term_s2[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= wgt.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// weight = hi * 2^32 + lo, lo taken as unsigned
			for (int i = 0; i < N_CORNER; i++) begin
				pl_s1[i] <= $signed(wgt.corner[i]) * $signed({1'b0, wgt.weight[i][31:0]});
				ph_s1[i] <= $signed(wgt.corner[i]) * $signed(wgt.weight[i][WGT_W-1:32]);
			end
			vol_s1 <= wgt.vol;

			for (int i = 0; i < N_CORNER; i++) begin
				term_s2[i] <= {ph_s1[i], 32'd0}
					+ {{(TERM_W-PL_W){pl_s1[i][PL_W-1]}}, pl_s1[i]};
			end
			vol_s2 <= vol_s1;

			for (int i = 0; i < 4; i++) begin
				sum_s3[i] <= term_x[2*i] + term_x[2*i+1];
			end
			vol_s3 <= vol_s2;

			sum_s4[0] <= sum_s3[0] + sum_s3[1];
			sum_s4[1] <= sum_s3[2] + sum_s3[3];
			vol_s4    <= vol_s3;

			sum_s5 <= sum_s4[0] + sum_s4[1];
			vol_s5 <= vol_s4;
		end
	end

	assign acc.valid = v_s5;
	assign acc.sum   = sum_s5;
	assign acc.vol   = vol_s5;

endmodule

// ===== design/tli_div.sv =====
// Pipelined restoring divider by the cell volume, one quotient bit per stage, with saturation.
module tli_div import tli_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  sum_bus_t acc,
	output res_bus_t res
);

	logic             v_s1, neg_s1;
	logic [ACC_W-1:0] mag_s1;
	logic [VOL_W-1:0] vol_s1;

	// index 0 is the setup stage, index k+1 follows quotient step k
	logic             dv_valid_s [QUO_W+1];
	logic             dv_neg_s   [QUO_W+1];
	logic             dv_ovf_s   [QUO_W+1];
	logic             dv_zero_s  [QUO_W+1];
	logic [QUO_W-1:0] dv_ql_s    [QUO_W+1];  // dividend low bits out, quotient bits in
	logic [VOL_W-1:0] dv_rem_s   [QUO_W];
	logic [VOL_W-1:0] dv_vol_s   [QUO_W];

	logic [QUO_W-1:0] quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			dv_valid_s[0] <= 1'b0;
		end else if (adv) begin
			v_s1          <= acc.valid;
			dv_valid_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= acc.sum[ACC_W-1];
			mag_s1 <= acc.sum[ACC_W-1] ? (~acc.sum + 1'b1) : acc.sum;
			vol_s1 <= acc.vol;

			// quotient reaches 2^32 exactly when mag >= vol * 2^32
			dv_ovf_s[0]  <= mag_s1[ACC_W-1:QUO_W] >= {{(ACC_W-QUO_W-VOL_W){1'b0}}, vol_s1};
			dv_rem_s[0]  <= mag_s1[QUO_W+VOL_W-1:QUO_W];
			dv_ql_s[0]   <= mag_s1[QUO_W-1:0];
			dv_neg_s[0]  <= neg_s1;
			dv_zero_s[0] <= vol_s1 == '0;
			dv_vol_s[0]  <= vol_s1;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [VOL_W:0] trial;
		logic [VOL_W:0] diff;
		logic           fits;

		assign trial = {dv_rem_s[k], dv_ql_s[k][QUO_W-1]};
		assign diff  = trial - {1'b0, dv_vol_s[k]};
		assign fits  = trial >= {1'b0, dv_vol_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				dv_valid_s[k+1] <= dv_valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ql_s[k+1]   <= {dv_ql_s[k][QUO_W-2:0], fits};
				dv_neg_s[k+1]  <= dv_neg_s[k];
				dv_ovf_s[k+1]  <= dv_ovf_s[k];
				dv_zero_s[k+1] <= dv_zero_s[k];
			end
		end

		if (k < QUO_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					dv_rem_s[k+1] <= fits ? diff[VOL_W-1:0] : trial[VOL_W-1:0];
					dv_vol_s[k+1] <= dv_vol_s[k];
				end
			end
		end
	end

	assign quo = dv_ql_s[QUO_W];

	always_comb begin
		res.valid = dv_valid_s[QUO_W];
		if (dv_zero_s[QUO_W]) begin
			res.value = '0;
			res.sat   = 1'b1;
		end else if (dv_neg_s[QUO_W]) begin
			if (dv_ovf_s[QUO_W] || quo > VAL_MIN) begin
				res.value = VAL_MIN;
				res.sat   = 1'b1;
			end else begin
				res.value = ~quo + 1'b1;
				res.sat   = 1'b0;
			end
		end else begin
			if (dv_ovf_s[QUO_W] || quo[QUO_W-1]) begin
				res.value = VAL_MAX;
				res.sat   = 1'b1;
			end else begin
				res.value = quo;
				res.sat   = 1'b0;
			end
		end
	end

	// partial remainder stays below the divisor through the steps
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid_s[QUO_W-1] && !dv_zero_s[QUO_W-1] && !dv_ovf_s[QUO_W-1]
		|-> dv_rem_s[QUO_W-1] < dv_vol_s[QUO_W-1])
		else $error("divider remainder not below cell volume");

	a_sat_rails: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.sat
		|-> res.value == VAL_MAX || res.value == VAL_MIN || res.value == '0)
		else $error("saturated result not at a rail or zero");

	a_zero_vol: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && dv_zero_s[QUO_W] |-> res.value == '0 && res.sat)
		else $error("zero cell volume did not give a flagged zero");

endmodule

// ===== design/trilinear_interpolator_core.sv =====
// Top level of the trilinear interpolator: config registers, pipeline and output register.
//
// Usage:
//   sample  : valid/ready channel carrying the three offsets and eight corner values.
//   result  : valid/ready channel carrying interpolated_value and the saturated flag.
//   cfg_*   : write-only port; cfg_index 0/1/2 selects cell_size_x/y/z, higher
//             indexes are ignored. Write only while no transaction is in flight.
// Throughput: one transaction per cycle, sustained, as long as result is taken.
// Pipeline: an accepted sample passes 3 weight stages, 5 multiply/add stages,
//   2 divider setup stages, 32 divider stages (one quotient bit each) and the
//   output register.
// Stalls: the whole pipeline holds while the output register is full and
//   result.ready is low; sample.ready drops in the same cycle, nothing is lost.
// Reset: arst_n clears all valid bits and sets the cell sizes to 256.
// A zero cell size yields 0 with the saturated flag set.
module trilinear_interpolator_core import tli_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CS_W-1:0]      cfg_data,
	tli_sample_if.sink           sample,
	tli_result_if.source         result
);

	logic [CS_W-1:0]  cs_x_q, cs_y_q, cs_z_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] out_value_q;
	logic             out_sat_q;
	logic             adv;
	corners_t         corner;
	wgt_bus_t         wgt;
	sum_bus_t         acc;
	res_bus_t         res;

	assign adv          = !out_valid_q || result.ready;
	assign sample.ready = adv;

	assign corner[0] = sample.corner_000;
	assign corner[1] = sample.corner_100;
	assign corner[2] = sample.corner_010;
	assign corner[3] = sample.corner_001;
	assign corner[4] = sample.corner_110;
	assign corner[5] = sample.corner_101;
	assign corner[6] = sample.corner_011;
	assign corner[7] = sample.corner_111;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_x_q <= CS_RESET;
			cs_y_q <= CS_RESET;
			cs_z_q <= CS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CELL_SIZE_X: cs_x_q <= cfg_data;
				REG_CELL_SIZE_Y: cs_y_q <= cfg_data;
				REG_CELL_SIZE_Z: cs_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tli_weights u_weights (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (sample.valid),
		.offset_x    (sample.offset_x),
		.offset_y    (sample.offset_y),
		.offset_z    (sample.offset_z),
		.corner      (corner),
		.cell_size_x (cs_x_q),
		.cell_size_y (cs_y_q),
		.cell_size_z (cs_z_q),
		.wgt         (wgt)
	);

	tli_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.wgt    (wgt),
		.acc    (acc)
	);

	tli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.acc    (acc),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_value_q <= res.value;
			out_sat_q   <= res.sat;
		end
	end

	assign result.valid              = out_valid_q;
	assign result.interpolated_value = out_value_q;
	assign result.saturated          = out_sat_q;

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !sample.ready)
		else $error("sample accepted while result is stalled");

	a_valid_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(sample.ready))
		else $error("result valid rose without a pipeline advance");

	a_unflagged_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.saturated
		|-> result.interpolated_value != VAL_MAX || out_value_q == VAL_MAX)
		else $error("output register does not match the result port");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for trilinear_interpolator_core: directed and random samples.
`timescale 1ns / 1ps

module testbench import tli_pkg::*; ();

	localparam int PIPE_LATENCY = 42;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	// corner position as {x, y, z}; a set bit weights by the offset, not the complement
	localparam logic [2:0] CORNER_POS [N_CORNER] = '{3'b000, 3'b100, 3'b010, 3'b001,
		3'b110, 3'b101, 3'b011, 3'b111};

	typedef struct packed {
		logic [2:0][OFS_W-1:0]          ofs;
		logic [N_CORNER-1:0][VAL_W-1:0] corner;
	} point_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             sat;
	} interp_t;

	typedef enum {STALL_NONE, STALL_RANDOM, STALL_THIRD, STALL_LONG, STALL_LIGHT} stall_mode_t;

	class interp_scoreboard;
		logic [2:0][CS_W-1:0] cell_len;
		interp_t expected_q[$];
		int errors;
		int checked;

		function new();
			cell_len = {3{CS_RESET}};
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CS_W-1:0] data);
			case (idx)
			REG_CELL_SIZE_X: cell_len[0] = data;
			REG_CELL_SIZE_Y: cell_len[1] = data;
			REG_CELL_SIZE_Z: cell_len[2] = data;
			default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function interp_t interpolate(point_t p);
			longint near_len [3];
			longint far_len [3];
			longint wgt;
			logic signed [127:0] acc;
			logic signed [127:0] cval;
			logic signed [127:0] wval;
			logic [127:0] mag;
			logic [127:0] quo;
			logic [127:0] vol;
			logic neg;
			interp_t r;
			int a;
			int i;
			vol = 128'(cell_len[0]) * 128'(cell_len[1]) * 128'(cell_len[2]);
			if (vol == 0) begin
				r.value = '0;
				r.sat = 1'b1;
				return r;
			end
			for (a = 0; a < 3; a++) begin
				near_len[a] = longint'(p.ofs[a]);
				far_len[a] = longint'(cell_len[a]) - near_len[a];   // negative when extrapolating
			end
			acc = '0;
			for (i = 0; i < N_CORNER; i++) begin
				wgt = (CORNER_POS[i][2] ? near_len[0] : far_len[0])
					* (CORNER_POS[i][1] ? near_len[1] : far_len[1])
					* (CORNER_POS[i][0] ? near_len[2] : far_len[2]);
				cval = $signed(p.corner[i]);
				wval = wgt;
				acc = acc + cval * wval;
			end
			neg = acc[127];
			mag = acc;
			if (neg)
				mag = -acc;
			quo = mag / vol;   // magnitude division: truncates toward zero
			if (neg) begin
				if (quo > 128'h8000_0000) begin
					r.value = VAL_MIN;
					r.sat = 1'b1;
				end else begin
					r.value = -quo[VAL_W-1:0];
					r.sat = 1'b0;
				end
			end else begin
				if (quo > 128'h7FFF_FFFF) begin
					r.value = VAL_MAX;
					r.sat = 1'b1;
				end else begin
					r.value = quo[VAL_W-1:0];
					r.sat = 1'b0;
				end
			end
			return r;
		endfunction

		function void note_sample(point_t p);
			expected_q.push_back(interpolate(p));
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(interp_t seen);
			interp_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result value=%h sat=%b", seen.value, seen.sat));
				return;
			end
			want = expected_q.pop_front();
			if (seen.value !== want.value)
				report($sformatf("result %0d: interpolated_value %h, expected %h",
					checked, seen.value, want.value));
			if (seen.sat !== want.sat)
				report($sformatf("result %0d: saturated %b, expected %b",
					checked, seen.sat, want.sat));
			checked++;
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CS_W-1:0]      cfg_data;

	tli_sample_if sample_ch ();
	tli_result_if result_ch ();

	interp_scoreboard sb = new();
	int burst_left = 0;

	trilinear_interpolator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	always #5 clk = ~clk;

	function automatic point_t make_point(input int unsigned ox, input int unsigned oy,
		input int unsigned oz, input logic [VAL_W-1:0] c000, input logic [VAL_W-1:0] c100,
		input logic [VAL_W-1:0] c010, input logic [VAL_W-1:0] c001,
		input logic [VAL_W-1:0] c110, input logic [VAL_W-1:0] c101,
		input logic [VAL_W-1:0] c011, input logic [VAL_W-1:0] c111);
		point_t p;
		p.ofs[0] = OFS_W'(ox);
		p.ofs[1] = OFS_W'(oy);
		p.ofs[2] = OFS_W'(oz);
		p.corner[0] = c000;
		p.corner[1] = c100;
		p.corner[2] = c010;
		p.corner[3] = c001;
		p.corner[4] = c110;
		p.corner[5] = c101;
		p.corner[6] = c011;
		p.corner[7] = c111;
		return p;
	endfunction

	function automatic logic [VAL_W-1:0] rand_corner();
		case ($urandom_range(0, 7))
		0: return VAL_MAX;
		1: return VAL_MIN;
		2, 3, 4: return $urandom;
		default: return VAL_W'(int'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000);
		endcase
	endfunction

	// mostly offsets inside the cell, some on its faces, some far beyond
	function automatic point_t rand_point();
		point_t p;
		int a;
		int i;
		for (a = 0; a < 3; a++) begin
			case ($urandom_range(0, 9))
			0: p.ofs[a] = '0;
			1: p.ofs[a] = sb.cell_len[a];
			2: p.ofs[a] = '1;
			3, 4: p.ofs[a] = OFS_W'($urandom);
			default: p.ofs[a] = OFS_W'($urandom_range(0, sb.cell_len[a]));
			endcase
		end
		for (i = 0; i < N_CORNER; i++)
			p.corner[i] = rand_corner();
		return p;
	endfunction

	task automatic send_point(input point_t p);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 40);
			repeat (gap) begin
				sample_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		burst_left--;
		sample_ch.valid      <= 1'b1;
		sample_ch.offset_x   <= p.ofs[0];
		sample_ch.offset_y   <= p.ofs[1];
		sample_ch.offset_z   <= p.ofs[2];
		sample_ch.corner_000 <= p.corner[0];
		sample_ch.corner_100 <= p.corner[1];
		sample_ch.corner_010 <= p.corner[2];
		sample_ch.corner_001 <= p.corner[3];
		sample_ch.corner_110 <= p.corner[4];
		sample_ch.corner_101 <= p.corner[5];
		sample_ch.corner_011 <= p.corner[6];
		sample_ch.corner_111 <= p.corner[7];
		do
			@(posedge clk);
		while (!sample_ch.ready);
		sb.note_sample(p);
	endtask

	task automatic run_points(input int count);
		repeat (count)
			send_point(rand_point());
	endtask

	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// drains the pipe, then writes all three sizes plus a write to the unused index
	task automatic configure(input logic [CS_W-1:0] sx, input logic [CS_W-1:0] sy,
		input logic [CS_W-1:0] sz);
		logic [REG_IDX_W-1:0] idx [4];
		logic [CS_W-1:0] data [4];
		int k;
		wait_idle();
		idx = '{REG_UNUSED, REG_CELL_SIZE_X, REG_CELL_SIZE_Y, REG_CELL_SIZE_Z};
		data = '{CS_W'($urandom), sx, sy, sz};
		for (k = 0; k < 4; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= data[k];
			@(posedge clk);
			sb.set_reg(idx[k], data[k]);
		end
		cfg_we <= 1'b0;
	endtask

	// result side stall pattern
	initial begin
		stall_mode_t mode;
		int span;
		int phase;
		result_ch.ready <= 1'b0;
		mode = STALL_NONE;
		span = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				mode = stall_mode_t'($urandom_range(0, 4));
				span = $urandom_range(16, 120);
			end
			span--;
			phase++;
			case (mode)
			STALL_NONE:   result_ch.ready <= 1'b1;
			STALL_RANDOM: result_ch.ready <= ($urandom_range(0, 1) == 1);
			STALL_THIRD:  result_ch.ready <= ((phase % 3) != 0);
			STALL_LONG:   result_ch.ready <= ((phase % 8) == 0);
			default:      result_ch.ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	initial begin
		interp_t seen;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				seen.value = result_ch.interpolated_value;
				seen.sat = result_ch.saturated;
				sb.check_result(seen);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= REG_CELL_SIZE_X;
		cfg_data             <= '0;
		sample_ch.valid      <= 1'b0;
		sample_ch.offset_x   <= '0;
		sample_ch.offset_y   <= '0;
		sample_ch.offset_z   <= '0;
		sample_ch.corner_000 <= '0;
		sample_ch.corner_100 <= '0;
		sample_ch.corner_010 <= '0;
		sample_ch.corner_001 <= '0;
		sample_ch.corner_110 <= '0;
		sample_ch.corner_101 <= '0;
		sample_ch.corner_011 <= '0;
		sample_ch.corner_111 <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset cell sizes: corners, faces, full-scale values, extrapolation
		send_point(make_point(0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
			32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0008_0000));
		send_point(make_point(256, 256, 256, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
			32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0008_0000));
		send_point(make_point(128, 64, 32, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
			VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX));
		send_point(make_point(200, 17, 99, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN,
			VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN));
		send_point(make_point(65535, 65535, 65535, '0, '0, '0, '0, '0, '0, '0, VAL_MAX));
		send_point(make_point(65535, 65535, 65535, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN,
			VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN));
		// tiny negative result must truncate to zero, not to -1
		send_point(make_point(1, 0, 0, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, '0));
		send_point(make_point(65535, 0, 0, VAL_MAX, VAL_MIN, '0, '0, '0, '0, '0, '0));
		send_point(make_point(0, 65535, 0, rand_corner(), rand_corner(), rand_corner(),
			rand_corner(), rand_corner(), rand_corner(), rand_corner(), rand_corner()));
		send_point(make_point(0, 0, 65535, rand_corner(), rand_corner(), rand_corner(),
			rand_corner(), rand_corner(), rand_corner(), rand_corner(), rand_corner()));
		send_point(make_point(300, 511, 256, rand_corner(), rand_corner(), rand_corner(),
			rand_corner(), rand_corner(), rand_corner(), rand_corner(), rand_corner()));
		run_points(140);

		configure(16'd1, 16'd1, 16'd1);
		send_point(make_point(0, 0, 0, rand_corner(), rand_corner(), rand_corner(),
			rand_corner(), rand_corner(), rand_corner(), rand_corner(), rand_corner()));
		send_point(make_point(1, 1, 1, rand_corner(), rand_corner(), rand_corner(),
			rand_corner(), rand_corner(), rand_corner(), rand_corner(), rand_corner()));
		send_point(make_point(65535, 65535, 65535, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX,
			VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX));
		run_points(140);

		configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_point(make_point(65535, 65535, 65535, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
			VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX));
		send_point(make_point(32768, 1, 65534, rand_corner(), rand_corner(), rand_corner(),
			rand_corner(), rand_corner(), rand_corner(), rand_corner(), rand_corner()));
		send_point(make_point(0, 0, 0, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN,
			VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN));
		run_points(140);

		// zero cell volume
		configure(16'd0, 16'd256, 16'd256);
		send_point(make_point(0, 0, 0, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
			VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX));
		send_point(make_point(65535, 65535, 65535, rand_corner(), rand_corner(),
			rand_corner(), rand_corner(), rand_corner(), rand_corner(), rand_corner(),
			rand_corner()));
		run_points(40);
		configure(16'd256, 16'd0, 16'd1);
		run_points(40);

		configure(16'd7, 16'hFFFF, 16'd300);
		run_points(150);
		configure(CS_W'($urandom_range(1, 65535)), CS_W'($urandom_range(1, 65535)),
			CS_W'($urandom_range(1, 65535)));
		run_points(150);
		configure(CS_W'($urandom_range(1, 64)), CS_W'($urandom_range(1, 64)),
			CS_W'($urandom_range(1, 64)));
		run_points(150);
		configure(16'd16, 16'd16, 16'd16);
		run_points(150);
		configure(CS_RESET, CS_RESET, CS_RESET);
		run_points(150);

		wait_idle();
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/tli_pkg.sv
design/tli_if.sv
design/tli_weights.sv
design/tli_mac.sv
design/tli_div.sv
design/trilinear_interpolator_core.sv
dv/testbench.sv
